// File: rtl/cksb_pkg.sv
// ----------------------------------------------------------------------------
// cksb_pkg
// shared types, register indexes, opcodes and widths of the sprite blitter
// ----------------------------------------------------------------------------
package cksb_pkg;

    localparam int COORD_BITS_DEF = 10;

    localparam int DIM_W   = 11;
    localparam int COLOR_W = 16;
    localparam int OP_W    = 3;
    localparam int ADDR_W  = 20;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd480;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd272;
    localparam logic [DIM_W-1:0]   PITCH_RST  = 11'd512;
    localparam logic [COLOR_W-1:0] KEY_RST    = 16'h0000;
    localparam logic [COLOR_W-1:0] BACK_RST   = 16'h0000;

    typedef enum logic [CIDX_W-1:0] {
        REG_CLIP_WIDTH    = 3'd0,
        REG_CLIP_HEIGHT   = 3'd1,
        REG_LINE_PITCH    = 3'd2,
        REG_KEY_COLOR     = 3'd3,
        REG_KEY_ENABLED   = 3'd4,
        REG_BACKGROUND    = 3'd5
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_OPAQUE   = 3'd0,
        OP_PUT_KEYED    = 3'd1,
        OP_PUT_MASKED   = 3'd2,
        OP_COLLIDE_ALL  = 3'd3,
        OP_COLLIDE_KEYED = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [DIM_W-1:0]   clip_width;
        logic [DIM_W-1:0]   clip_height;
        logic [DIM_W-1:0]   line_pitch;
        logic [COLOR_W-1:0] key_color;
        logic               key_enabled;
        logic [COLOR_W-1:0] background_color;
    } cfg_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic              visible;
        logic              hit_now;
    } pix_res_t;

endpackage

// File: rtl/cksb_cfg_regs.sv
// ----------------------------------------------------------------------------
// cksb_cfg_regs
// configuration register file, written one register per transaction
// ----------------------------------------------------------------------------
module cksb_cfg_regs
    import cksb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [CIDX_W-1:0]  wr_idx,
    input  logic [CDATA_W-1:0] wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_idx)
                REG_CLIP_WIDTH:    cfg_next.clip_width       = wr_data[DIM_W-1:0];
                REG_CLIP_HEIGHT:   cfg_next.clip_height      = wr_data[DIM_W-1:0];
                REG_LINE_PITCH:    cfg_next.line_pitch       = wr_data[DIM_W-1:0];
                REG_KEY_COLOR:     cfg_next.key_color        = wr_data[COLOR_W-1:0];
                REG_KEY_ENABLED:   cfg_next.key_enabled      = wr_data[0];
                REG_BACKGROUND:    cfg_next.background_color = wr_data[COLOR_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_width       <= WIDTH_RST;
            cfg_reg.clip_height      <= HEIGHT_RST;
            cfg_reg.line_pitch       <= PITCH_RST;
            cfg_reg.key_color        <= KEY_RST;
            cfg_reg.key_enabled      <= 1'b0;
            cfg_reg.background_color <= BACK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/cksb_pixel_eval.sv
// ----------------------------------------------------------------------------
// cksb_pixel_eval
// clip test, framebuffer address and write / collision decision for a pixel
// ----------------------------------------------------------------------------
module cksb_pixel_eval
    import cksb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  cfg_t                   cfg,
    input  logic [OP_W-1:0]        opcode,
    input  logic [DIM_W-1:0]       dest_x,
    input  logic [DIM_W-1:0]       dest_y,
    input  logic [COORD_BITS-1:0]  column,
    input  logic [COORD_BITS-1:0]  row,
    input  logic [COLOR_W-1:0]     src_color,
    input  logic                   mask_bit,
    input  logic [COLOR_W-1:0]     screen_pixel,
    output pix_res_t               res
);

    // signed screen coordinate width, one spare bit over the widest operand
    localparam int SW   = ((COORD_BITS > DIM_W - 1) ? COORD_BITS : DIM_W - 1) + 2;
    localparam int PW   = 2 * DIM_W;

    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic                 vis;
    logic                 opaque;
    logic                 occupied;
    logic [PW-1:0]        prod;
    logic [PW-1:0]        sum;

    always_comb
    begin
        sx = $signed({{(SW-DIM_W){dest_x[DIM_W-1]}}, dest_x})
           + $signed({{(SW-COORD_BITS){1'b0}}, column});
        sy = $signed({{(SW-DIM_W){dest_y[DIM_W-1]}}, dest_y})
           + $signed({{(SW-COORD_BITS){1'b0}}, row});
    end

    assign vis = !sx[SW-1] && !sy[SW-1]
              && (sx[SW-2:0] < (SW-1)'(cfg.clip_width))
              && (sy[SW-2:0] < (SW-1)'(cfg.clip_height));

    assign opaque   = !(cfg.key_enabled && (src_color == cfg.key_color));
    assign occupied = (screen_pixel != cfg.background_color);

    // a visible coordinate is below the 11-bit bound, so the low bits suffice
    assign prod = {{(PW-DIM_W){1'b0}}, sy[DIM_W-1:0]}
                * {{(PW-DIM_W){1'b0}}, cfg.line_pitch};
    assign sum  = prod + {{(PW-DIM_W){1'b0}}, sx[DIM_W-1:0]};

    always_comb
    begin
        res.write_enable  = 1'b0;
        res.hit_now       = 1'b0;
        res.visible       = vis;
        res.write_address = '0;
        if (vis)
        begin
            res.write_address = sum[ADDR_W-1:0];
            case (opcode)
                OP_PUT_OPAQUE:    res.write_enable = 1'b1;
                OP_PUT_KEYED:     res.write_enable = opaque;
                OP_PUT_MASKED:    res.write_enable = mask_bit;
                OP_COLLIDE_ALL:   res.hit_now      = occupied;
                OP_COLLIDE_KEYED: res.hit_now      = opaque && occupied;
                default:
                begin
                    res.write_enable = 1'b0;
                    res.hit_now      = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: rtl/clipped_keyed_sprite_blitter.sv
// ----------------------------------------------------------------------------
// clipped_keyed_sprite_blitter
// per-pixel clip, address, color-key, mask and collision engine for rgb565 sprite blits
// ----------------------------------------------------------------------------
// channel  | direction | carries
// s_axis   | in        | one source pixel transaction, tlast marks end of blit
// m_axis   | out       | one result transaction per pixel
// cfg      | in        | register index and write data, always ready
//
// one pixel per clock sustained while m_axis accepts; each pixel passes the
// input register, then the result register, with clip, multiply-add address
// and collision logic between; the input register refills while a result
// waits, so a stalled m_axis backs up s_axis only when both registers are full
// reset restores the default screen geometry and clears the hit flag
// ----------------------------------------------------------------------------
module clipped_keyed_sprite_blitter
    import cksb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_BITS   = 2 * DIM_W + 2 * COORD_BITS + 2 * COLOR_W + 1,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = ADDR_W + COLOR_W + 3,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_tvalid,
    output logic               s_tready,
    // dest_x, dest_y, column, row, src_color, mask_bit, screen_pixel, zero fill
    input  logic [IN_W-1:0]    s_tdata,
    // opcode
    input  logic [OP_W-1:0]    s_tuser,
    input  logic               s_tlast,

    output logic               m_tvalid,
    input  logic               m_tready,
    // write_enable, write_address, write_color, visible, hit, zero fill
    output logic [OUT_W-1:0]   m_tdata,
    output logic               m_tlast,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_addr,
    input  logic [CDATA_W-1:0] cfg_data
);

    localparam int DX_LO  = 0;
    localparam int DY_LO  = DX_LO + DIM_W;
    localparam int COL_LO = DY_LO + DIM_W;
    localparam int ROW_LO = COL_LO + COORD_BITS;
    localparam int SRC_LO = ROW_LO + COORD_BITS;
    localparam int MSK_LO = SRC_LO + COLOR_W;
    localparam int SCR_LO = MSK_LO + 1;

    cfg_t     cfg;
    pix_res_t res;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [IN_W-1:0]   in_data_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic              in_last_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;
    logic              out_last_reg;

    logic              seen_reg;
    logic              seen_next;
    logic              hit;
    logic              advance;
    logic              take;

    assign cfg_ready = 1'b1;

    cksb_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid),
        .wr_idx  (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    cksb_pixel_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval
    (
        .cfg          (cfg),
        .opcode       (in_op_reg),
        .dest_x       (in_data_reg[DX_LO +: DIM_W]),
        .dest_y       (in_data_reg[DY_LO +: DIM_W]),
        .column       (in_data_reg[COL_LO +: COORD_BITS]),
        .row          (in_data_reg[ROW_LO +: COORD_BITS]),
        .src_color    (in_data_reg[SRC_LO +: COLOR_W]),
        .mask_bit     (in_data_reg[MSK_LO]),
        .screen_pixel (in_data_reg[SCR_LO +: COLOR_W]),
        .res          (res)
    );

    // input holds a pixel and the result register is free or draining this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign hit = seen_reg | res.hit_now;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        seen_next      = seen_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            in_valid_next  = 1'b0;
            seen_next      = in_last_reg ? 1'b0 : hit;
        end
        if (take)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        out_data_next                         = '0;
        out_data_next[0]                      = res.write_enable;
        out_data_next[1 +: ADDR_W]            = res.write_address;
        out_data_next[1 + ADDR_W +: COLOR_W]  = in_data_reg[SRC_LO +: COLOR_W];
        out_data_next[1 + ADDR_W + COLOR_W]   = res.visible;
        out_data_next[2 + ADDR_W + COLOR_W]   = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
